// ===== rtl/modexp_pkg.sv =====
// package for the modular exponentiation block: widths, register map and sequencer states
`default_nettype none

package modexp_pkg;

  // width of the item fields and of the configuration data bus
  localparam int unsigned MODEXP_FIELD_W = 32;

  // default operand width used by the arithmetic
  localparam int unsigned MODEXP_WIDTH = 32;

  // byte address width of the configuration port
  localparam int unsigned MODEXP_ADDR_W = 3;

  // register indexes (byte address / 4)
  localparam logic [MODEXP_ADDR_W-3:0] MODEXP_REG_MODULUS = 1'b0;

  // reset value of the modulus register
  localparam logic [MODEXP_FIELD_W-1:0] MODEXP_MODULUS_RST = 32'd1;

  typedef enum logic [2:0] {
    ME_IDLE,
    ME_REDUCE,
    ME_MUL,
    ME_SQR,
    ME_DONE
  } modexp_state_t;

endpackage : modexp_pkg

`default_nettype wire

// ===== rtl/modular_exponentiation.sv =====
// modular exponentiation by right-to-left square-and-multiply over one shared modular multiplier
// the base is reduced first, then each exponent bit takes an optional multiply and a square;
// all of these run on the single shift-add modular multiplier, one bit per cycle, and a new
// item is taken only after the last one has handed its result to the output register
// reset (synchronous, rst_n low) returns the sequencer to idle, drops out_valid, sets modulus to 1
// a finished result waits in the output register while the next item is already accepted
`default_nettype none

module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int unsigned WIDTH = MODEXP_WIDTH
) (
  input  wire                        clk,
  input  wire                        rst_n,

  // input item channel
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire  [MODEXP_FIELD_W-1:0]  in_base,
  input  wire  [MODEXP_FIELD_W-1:0]  in_exponent,

  // result item channel
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic [MODEXP_FIELD_W-1:0]  out_result,

  // configuration port
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire  [MODEXP_ADDR_W-1:0]   paddr,
  input  wire  [MODEXP_FIELD_W-1:0]  pwdata,
  output logic [MODEXP_FIELD_W-1:0]  prdata,
  output logic                       pready
);

  // bit counter width for one multiplication and for the exponent scan
  localparam int unsigned CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  modexp_state_t              state_r, state_nxt;
  logic [MODEXP_FIELD_W-1:0]  mod_r, mod_nxt;        // modulus register
  logic [WIDTH-1:0]           pot_r, pot_nxt;        // running power
  logic [WIDTH-1:0]           acc_r, acc_nxt;        // accumulator
  logic [WIDTH-1:0]           exp_r, exp_nxt;        // exponent, shifted right per bit
  logic [CNT_W-1:0]           ecnt_r, ecnt_nxt;      // exponent bits left
  logic [WIDTH-1:0]           b_r, b_nxt;            // multiplier operand, scanned msb first
  logic [WIDTH-1:0]           r_r, r_nxt;            // partial product remainder
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;        // multiplier bits left
  logic                       out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0]           result_r, result_nxt;

  // ---------------------------------------------------------------------------
  // shared modular multiplier step: r = (2r + b_bit*a) mod m
  // operands stay below m, so each reduction is a single conditional subtract;
  // a modulus of zero means plain wrap modulo 2^WIDTH
  // ---------------------------------------------------------------------------
  logic [WIDTH-1:0] mod_w;
  logic             mod_zero;
  logic [WIDTH-1:0] a_op;
  logic [WIDTH:0]   dbl;
  logic [WIDTH+1:0] dbl_sub;
  logic [WIDTH-1:0] dbl_red;
  logic [WIDTH:0]   sum;
  logic [WIDTH+1:0] sum_sub;
  logic [WIDTH-1:0] r_new;

  assign mod_w    = mod_r[WIDTH-1:0];
  assign mod_zero = (mod_w == '0);

  // base reduction is base * 1 mod m, so the multiplicand is one there
  assign a_op = (state_r == ME_REDUCE) ? WIDTH'(1) : pot_r;

  assign dbl     = {r_r, 1'b0};
  assign dbl_sub = {1'b0, dbl} - {2'b00, mod_w};
  assign dbl_red = (mod_zero || dbl_sub[WIDTH+1]) ? dbl[WIDTH-1:0] : dbl_sub[WIDTH-1:0];

  assign sum     = b_r[WIDTH-1] ? ({1'b0, dbl_red} + {1'b0, a_op}) : {1'b0, dbl_red};
  assign sum_sub = {1'b0, sum} - {2'b00, mod_w};
  assign r_new   = (mod_zero || sum_sub[WIDTH+1]) ? sum[WIDTH-1:0] : sum_sub[WIDTH-1:0];

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  logic in_accept;
  logic cfg_write;

  assign in_stall   = (state_r != ME_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_result = MODEXP_FIELD_W'(result_r);

  // modulus is written on the access cycle of an apb write to its address
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite
                     && (paddr[MODEXP_ADDR_W-1:2] == MODEXP_REG_MODULUS);
  assign prdata    = (paddr[MODEXP_ADDR_W-1:2] == MODEXP_REG_MODULUS) ? mod_r : '0;

  // ---------------------------------------------------------------------------
  // state register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ME_IDLE;
      out_valid_r <= 1'b0;
      mod_r       <= MODEXP_MODULUS_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      mod_r       <= mod_nxt;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    pot_r    <= pot_nxt;
    acc_r    <= acc_nxt;
    exp_r    <= exp_nxt;
    ecnt_r   <= ecnt_nxt;
    b_r      <= b_nxt;
    r_r      <= r_nxt;
    cnt_r    <= cnt_nxt;
    result_r <= result_nxt;
  end

  // ---------------------------------------------------------------------------
  // sequencer: reduce base, then per exponent bit an optional multiply and a square
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    mod_nxt       = cfg_write ? pwdata : mod_r;
    pot_nxt       = pot_r;
    acc_nxt       = acc_r;
    exp_nxt       = exp_r;
    ecnt_nxt      = ecnt_r;
    b_nxt         = b_r;
    r_nxt         = r_r;
    cnt_nxt       = cnt_r;
    result_nxt    = result_r;
    // a waiting result leaves when the sink takes it
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ME_IDLE: begin
        if (in_valid) begin
          b_nxt     = in_base[WIDTH-1:0];
          exp_nxt   = in_exponent[WIDTH-1:0];
          acc_nxt   = WIDTH'(1);
          r_nxt     = '0;
          cnt_nxt   = CNT_LAST;
          ecnt_nxt  = CNT_LAST;
          state_nxt = ME_REDUCE;
        end
      end

      ME_REDUCE, ME_MUL, ME_SQR: begin
        // one multiplier bit per cycle
        r_nxt   = r_new;
        b_nxt   = {b_r[WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          // product done: write back and set up the next one
          r_nxt   = '0;
          cnt_nxt = CNT_LAST;
          case (state_r)
            ME_REDUCE: begin
              pot_nxt = r_new;
              if (exp_r[0]) begin
                state_nxt = ME_MUL;
                b_nxt     = acc_r;
              end else begin
                state_nxt = ME_SQR;
                b_nxt     = r_new;
              end
            end
            ME_MUL: begin
              acc_nxt   = r_new;
              state_nxt = ME_SQR;
              b_nxt     = pot_r;
            end
            default: begin
              // square finished, move on to the next exponent bit
              pot_nxt = r_new;
              if (ecnt_r == '0) begin
                state_nxt = ME_DONE;
              end else begin
                exp_nxt  = exp_r >> 1;
                ecnt_nxt = ecnt_r - 1'b1;
                if (exp_r[1]) begin
                  state_nxt = ME_MUL;
                  b_nxt     = acc_r;
                end else begin
                  state_nxt = ME_SQR;
                  b_nxt     = r_new;
                end
              end
            end
          endcase
        end
      end

      ME_DONE: begin
        // hand over once the output register is free
        if (!out_valid_r || !out_stall) begin
          result_nxt    = acc_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ME_IDLE;
        end
      end

      default: begin
        state_nxt = ME_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a new result only appears out of the done state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ME_DONE))
    else $error("result raised outside done state");

  // an accepted item starts with the base reduction
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ME_REDUCE))
    else $error("accepted item did not start reduction");

  // the partial remainder stays reduced while multiplying
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ME_REDUCE) || (state_r == ME_MUL) || (state_r == ME_SQR)) && !mod_zero
      |-> (r_r < mod_w))
    else $error("partial remainder not below modulus");

  // the running power is reduced before it is used as multiplicand
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ME_MUL) || (state_r == ME_SQR)) && !mod_zero |-> (pot_r < mod_w))
    else $error("running power not below modulus");

  // the user must keep the modulus unchanged while an item is in work; the block does not enforce it
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ME_IDLE) && $past(state_r != ME_IDLE) |-> $stable(mod_r))
    else $error("modulus changed during an item");

endmodule : modular_exponentiation

`default_nettype wire

// ===== dv/tb.sv =====
// testbench for modular_exponentiation: queue-fed driver, result checker and register port
`timescale 1ns / 100ps
`default_nettype none

module tb;
  import modexp_pkg::*;

  // operand width used by the arithmetic, same default as the block
  localparam int unsigned OPW = MODEXP_WIDTH;
  localparam logic [63:0] OP_MASK = (64'd1 << OPW) - 64'd1;

  // index with no register behind it, writes there must be dropped
  localparam logic [MODEXP_ADDR_W-3:0] REG_UNUSED = 1'b1;

  // cycles with no item moving on either channel before the run is called dead
  localparam int unsigned WATCHDOG_LIMIT = 40000;
  // long receiver hold-off, enough to back the block up into its input
  localparam int unsigned HOLD_CYCLES = 6000;
  // settle time at the end, one worst-case item
  localparam int unsigned TAIL_CYCLES = 2100;
  // window of items in which neither side idles
  localparam int unsigned CALM_FIRST = 150;
  localparam int unsigned CALM_LAST = 200;

  typedef struct packed {
    logic [MODEXP_FIELD_W-1:0] base;
    logic [MODEXP_FIELD_W-1:0] exponent;
  } operands_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [MODEXP_FIELD_W-1:0] in_base = '0;
  logic [MODEXP_FIELD_W-1:0] in_exponent = '0;

  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [MODEXP_FIELD_W-1:0] out_result;

  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [MODEXP_ADDR_W-1:0]  paddr = '0;
  logic [MODEXP_FIELD_W-1:0] pwdata = '0;
  logic [MODEXP_FIELD_W-1:0] prdata;
  logic                      pready;

  modular_exponentiation i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_base     (in_base),
    .in_exponent (in_exponent),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_result  (out_result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // items waiting to be offered, and results owed by the block in order
  operands_t                 operand_queue[$];
  logic [MODEXP_FIELD_W-1:0] owed_results[$];

  // modulus as the block should hold it
  logic [MODEXP_FIELD_W-1:0] cur_modulus;

  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int stall_hold = 0;
  bit hold_used = 1'b0;
  int quiet_cycles = 0;
  logic [MODEXP_FIELD_W-1:0] want_result;

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic flag_error(string what, logic [MODEXP_FIELD_W-1:0] got,
                            logic [MODEXP_FIELD_W-1:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // one reduction step, modulus zero means plain wrap at the operand width
  function automatic logic [63:0] mod_reduce(logic [63:0] v, logic [63:0] m);
    if (m == 64'd0) return v & OP_MASK;
    return v % m;
  endfunction

  // right-to-left square-and-multiply, accumulator is never reduced before the first multiply
  function automatic logic [MODEXP_FIELD_W-1:0] mod_power(logic [MODEXP_FIELD_W-1:0] b,
                                                          logic [MODEXP_FIELD_W-1:0] e,
                                                          logic [MODEXP_FIELD_W-1:0] m);
    logic [63:0] mm;
    logic [63:0] ee;
    logic [63:0] pw;
    logic [63:0] acc;
    mm = {32'd0, m} & OP_MASK;
    ee = {32'd0, e} & OP_MASK;
    pw = mod_reduce({32'd0, b} & OP_MASK, mm);
    acc = 64'd1;
    for (int i = 0; i < OPW; i++) begin
      if (ee[i]) acc = mod_reduce(pw * acc, mm);
      pw = mod_reduce(pw * pw, mm);
    end
    return acc[MODEXP_FIELD_W-1:0];
  endfunction

  // random operands biased toward the interesting corners
  function automatic operands_t make_operands();
    operands_t op;
    case ($urandom_range(9))
      6: op.base = $urandom_range(15);
      7: op.base = 32'hFFFF_FFFF - $urandom_range(15);
      8: op.base = cur_modulus + $urandom_range(3) - 1;
      default: op.base = $urandom;
    endcase
    case ($urandom_range(9))
      6: op.exponent = '0;
      7: op.exponent = $urandom_range(64);
      8: op.exponent = 32'hFFFF_FFFF;
      9: op.exponent = 32'd1 << $urandom_range(31);
      default: op.exponent = $urandom;
    endcase
    return op;
  endfunction

  task automatic queue_item(logic [MODEXP_FIELD_W-1:0] b, logic [MODEXP_FIELD_W-1:0] e);
    operand_queue.push_back('{base: b, exponent: e});
  endtask

  // apb write: setup cycle, then access until pready
  task automatic reg_write(logic [MODEXP_ADDR_W-3:0] idx, logic [MODEXP_FIELD_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == MODEXP_REG_MODULUS) cur_modulus = data;
  endtask

  // apb read of the modulus, checked against the expected copy
  task automatic check_modulus();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {MODEXP_REG_MODULUS, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== cur_modulus) flag_error("modulus readback", prdata, cur_modulus);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_modulus(logic [MODEXP_FIELD_W-1:0] m);
    reg_write(MODEXP_REG_MODULUS, m);
    check_modulus();
  endtask

  // block is idle once every queued item went in and every owed result came out
  task automatic wait_drained();
    do @(negedge clk);
    while (operand_queue.size() != 0 || in_valid || owed_results.size() != 0);
  endtask

  // stimulus: directed corners per modulus setting, then random phases
  initial begin
    logic [MODEXP_FIELD_W-1:0] rand_moduli[6];
    cur_modulus = MODEXP_MODULUS_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset modulus of one, exponent zero still gives one
    check_modulus();
    queue_item(32'd7, 32'd0);
    queue_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(32'd0, 32'd0);
    wait_drained();

    // write to an index with no register, modulus must stay put
    reg_write(REG_UNUSED, 32'hDEAD_BEEF);
    check_modulus();
    queue_item(32'd3, 32'd1);
    wait_drained();

    // modulus zero: plain wrap at the operand width
    set_modulus(32'd0);
    queue_item(32'd3, 32'd5);
    queue_item(32'hFFFF_FFFF, 32'd2);
    queue_item(32'd2, 32'd32);
    queue_item(32'd0, 32'd0);
    queue_item(32'd0, 32'd1);
    wait_drained();

    // largest modulus
    set_modulus(32'hFFFF_FFFF);
    queue_item(32'hFFFF_FFFF, 32'd5);
    queue_item(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    queue_item(32'd2, 32'hFFFF_FFFF);
    queue_item(32'h1234_5678, 32'h8000_0000);
    queue_item(32'd1, 32'hFFFF_FFFF);
    wait_drained();

    // largest 32-bit prime, fermat corner included
    set_modulus(32'hFFFF_FFFB);
    queue_item(32'd0, 32'd0);
    queue_item(32'd0, 32'd7);
    queue_item(32'd5, 32'hFFFF_FFFA);
    queue_item(32'hFFFF_FFFF, 32'd1);
    wait_drained();

    // modulus two
    set_modulus(32'd2);
    queue_item(32'd3, 32'hFFFF_FFFF);
    queue_item(32'hFFFF_FFFE, 32'd9);
    queue_item(32'd5, 32'd0);
    wait_drained();

    // random phases across a spread of moduli
    rand_moduli[0] = $urandom | 32'd1;
    rand_moduli[1] = $urandom;
    rand_moduli[2] = $urandom_range(255, 2);
    rand_moduli[3] = 32'h8000_0000;
    rand_moduli[4] = 32'd0;
    rand_moduli[5] = $urandom_range(65535, 1);
    foreach (rand_moduli[p]) begin
      set_modulus(rand_moduli[p]);
      repeat (45) operand_queue.push_back(make_operands());
      wait_drained();
    end

    // let any stray result show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // input driver: holds a stalled item, predicts each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      // item held until the block takes it
    end else begin
      if (in_valid) begin
        owed_results.push_back(mod_power(in_base, in_exponent, cur_modulus));
        n_sent <= n_sent + 1;
      end
      if (operand_queue.size() != 0 &&
          ((n_sent >= CALM_FIRST && n_sent < CALM_LAST) || $urandom_range(99) >= 30)) begin
        in_valid <= 1'b1;
        in_base <= operand_queue[0].base;
        in_exponent <= operand_queue[0].exponent;
        void'(operand_queue.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result checker: every accepted result against the oldest owed one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        flag_error("unexpected result", out_result, '0);
      end else begin
        want_result = owed_results.pop_front();
        if (out_result !== want_result) flag_error("result", out_result, want_result);
      end
      n_recv <= n_recv + 1;
    end
  end

  // receiver stall: random idling, one long hold-off while items keep coming
  always @(posedge clk) begin
    if (!hold_used && n_recv >= 40 && operand_queue.size() > 10) begin
      hold_used <= 1'b1;
      stall_hold <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (stall_hold != 0) stall_hold <= stall_hold - 1;
      out_stall <= (stall_hold > 1) ||
                   (!(n_recv >= CALM_FIRST && n_recv < CALM_LAST) && $urandom_range(99) < 30);
    end
  end

  // watchdog on cycles with no item moving either way
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d results still owed", owed_results.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

`default_nettype wire
